// ===== sv/dtlsrp_pkg.sv =====
// Shared types and constants of the DTLS record header parser.
`default_nettype none
package dtlsrp_pkg;

   localparam int OFFSET_BITS_DEFAULT = 16;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_INDEX_BIT = 2;
   localparam logic REG_MAX_RECORD_LENGTH = 1'b0;
   localparam logic [15:0] MAX_RECORD_LENGTH_RESET = 16'd18432;

   localparam logic [3:0] HDR_LAST_BYTE = 4'd12;
   localparam logic [7:0] TYPE_MIN = 8'd20;
   localparam logic [7:0] TYPE_MAX = 8'd23;
   localparam logic [15:0] VERSION_DTLS12 = 16'hfefd;
   localparam logic [15:0] VERSION_DTLS10 = 16'hfeff;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_datagram;
   } req_item_type;

   typedef struct packed {
      logic [4:0]  record_type;
      logic [15:0] record_version;
      logic [15:0] record_epoch;
      logic [47:0] record_sequence;
      logic [15:0] body_length;
      logic [15:0] body_offset;
   } rsp_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage
`default_nettype wire

// ===== sv/dtlsrp_front.sv =====
// Front end: byte-wise header capture, record tracking and descriptor build.
`default_nettype none
module dtlsrp_front #(
   parameter int OFFSET_BITS = dtlsrp_pkg::OFFSET_BITS_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    accept,
   input  wire dtlsrp_pkg::req_item_type item,
   input  wire logic [15:0]             max_len,
   output logic                         push,
   output dtlsrp_pkg::rsp_item_type     desc
);

   localparam int LW = (OFFSET_BITS > 16) ? OFFSET_BITS : 16;
   localparam logic [OFFSET_BITS-1:0] OFF_ONE = {{(OFFSET_BITS-1){1'b0}}, 1'b1};
   localparam logic [LW-1:0] WIDE_ONE = {{(LW-1){1'b0}}, 1'b1};

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_BODY,
      PH_STOPPED
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [3:0]             count_ff, count_in;
   logic [15:0]            remain_ff, remain_in;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   logic [7:0]             type_ff, type_in;
   logic [15:0]            version_ff, version_in;
   logic [15:0]            epoch_ff, epoch_in;
   logic [47:0]            seq_ff, seq_in;
   logic [15:0]            len_ff, len_in;
   logic                   finish;
   logic                   type_ok;
   logic                   version_ok;
   logic [LW-1:0]          start_wide;
   logic [OFFSET_BITS-1:0] start;

   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      remain_in  = remain_ff;
      type_in    = type_ff;
      version_in = version_ff;
      epoch_in   = epoch_ff;
      seq_in     = seq_ff;
      len_in     = len_ff;
      finish     = 1'b0;
      unique case (phase_ff)
         PH_HEADER: begin
            priority if (count_ff == 4'd0) begin
               type_in = item.data_byte;
            end else if (count_ff <= 4'd2) begin
               version_in = {version_ff[7:0], item.data_byte};
            end else if (count_ff <= 4'd4) begin
               epoch_in = {epoch_ff[7:0], item.data_byte};
            end else if (count_ff <= 4'd10) begin
               seq_in = {seq_ff[39:0], item.data_byte};
            end else begin
               len_in = {len_ff[7:0], item.data_byte};
            end
            if (count_ff == dtlsrp_pkg::HDR_LAST_BYTE) begin
               count_in = 4'd0;
               priority if (len_in > max_len) begin
                  phase_in = PH_STOPPED;
               end else if (len_in == 16'd0) begin
                  finish = 1'b1;
               end else begin
                  phase_in  = PH_BODY;
                  remain_in = len_in;
               end
            end else begin
               count_in = count_ff + 4'd1;
            end
         end
         PH_BODY: begin
            remain_in = remain_ff - 16'd1;
            if (remain_in == 16'd0) begin
               finish   = 1'b1;
               phase_in = PH_HEADER;
            end
         end
         default: begin
            // stopped or unused code: drop bytes until the datagram ends
         end
      endcase
      if (item.end_of_datagram) begin
         phase_in  = PH_HEADER;
         count_in  = 4'd0;
         remain_in = 16'd0;
         offset_in = '0;
      end else begin
         offset_in = offset_ff + OFF_ONE;
      end
   end

   assign type_ok    = (type_in >= dtlsrp_pkg::TYPE_MIN) && (type_in <= dtlsrp_pkg::TYPE_MAX);
   assign version_ok = (version_in == dtlsrp_pkg::VERSION_DTLS12) ||
                       (version_in == dtlsrp_pkg::VERSION_DTLS10);
   assign push       = accept && finish && type_ok && version_ok;

   // body start = offset of the closing byte - length + 1, modulo the offset width
   assign start_wide = LW'(offset_ff) - LW'(len_in) + WIDE_ONE;
   assign start      = start_wide[OFFSET_BITS-1:0];

   always_comb begin
      desc.record_type     = type_in[4:0];
      desc.record_version  = version_in;
      desc.record_epoch    = epoch_in;
      desc.record_sequence = seq_in;
      desc.body_length     = len_in;
      desc.body_offset     = 16'(start);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         count_ff  <= 4'd0;
         remain_ff <= 16'd0;
         offset_ff <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         remain_ff <= remain_in;
         offset_ff <= offset_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         type_ff    <= type_in;
         version_ff <= version_in;
         epoch_ff   <= epoch_in;
         seq_ff     <= seq_in;
         len_ff     <= len_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/dtlsrp_queue.sv =====
// Short descriptor queue between the front end and the result stage.
`default_nettype none
module dtlsrp_queue #(
   parameter int DEPTH = dtlsrp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire dtlsrp_pkg::rsp_item_type push_data,
   input  wire logic                     pop,
   output dtlsrp_pkg::rsp_item_type      head,
   output dtlsrp_pkg::queue_status_type  status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   dtlsrp_pkg::rsp_item_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ===== sv/dtlsrp_back.sv =====
// Result stage: output register that presents the oldest descriptor.
`default_nettype none
module dtlsrp_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire dtlsrp_pkg::queue_status_type q_status,
   input  wire dtlsrp_pkg::rsp_item_type q_head,
   output logic                          q_pop,
   input  wire logic                     rsp_pop,
   output logic                          rsp_empty,
   output dtlsrp_pkg::rsp_item_type      rsp_data
);

   logic                     valid_ff, valid_in;
   dtlsrp_pkg::rsp_item_type data_ff;

   // refill whenever the register is free or being taken this cycle
   assign q_pop = !q_status.empty && (!valid_ff || rsp_pop);

   always_comb begin
      valid_in = valid_ff;
      if (q_pop) begin
         valid_in = 1'b1;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         data_ff <= q_head;
      end
   end

   assign rsp_empty = !valid_ff;
   assign rsp_data  = data_ff;

endmodule
`default_nettype wire

// ===== sv/dtls_record_header_parser_core.sv =====
// Top level of the DTLS record header parser.
// Takes one datagram byte per cycle while req_full is low and emits one
// descriptor per accepted DTLS 1.2 or 1.0 record (type 20..23, version 0xfefd
// or 0xfeff, length up to max_record_length) that fits in the datagram. The
// front end captures header fields and counts body bytes with one registered
// update per byte; req_full rises only while the QUEUE_DEPTH-entry descriptor
// queue is full. A descriptor for a completed record reaches the result ports
// through the queue write, then the output register. max_record_length sits
// at byte address 0 of the csr port and must be written while idle.
`default_nettype none
module dtls_record_header_parser_core #(
   parameter int OFFSET_BITS = dtlsrp_pkg::OFFSET_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = dtlsrp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_push,
   output logic                                      req_full,
   input  wire dtlsrp_pkg::req_item_type             req_data,
   output logic                                      rsp_empty,
   input  wire logic                                 rsp_pop,
   output dtlsrp_pkg::rsp_item_type                  rsp_data,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [dtlsrp_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [dtlsrp_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [dtlsrp_pkg::CSR_DATA_BITS-1:0]      csr_prdata,
   output logic                                      csr_pready
);

   logic [15:0]                  max_len_ff;
   logic                         csr_write;
   logic                         csr_hit;
   logic                         accept;
   logic                         front_push;
   dtlsrp_pkg::rsp_item_type     front_desc;
   dtlsrp_pkg::rsp_item_type     q_head;
   dtlsrp_pkg::queue_status_type q_status;
   logic                         q_pop;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[dtlsrp_pkg::CSR_INDEX_BIT] == dtlsrp_pkg::REG_MAX_RECORD_LENGTH);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = csr_hit ? dtlsrp_pkg::CSR_DATA_BITS'(max_len_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= dtlsrp_pkg::MAX_RECORD_LENGTH_RESET;
      end else if (csr_write && csr_hit) begin
         max_len_ff <= csr_pwdata[15:0];
      end
   end

   assign req_full = q_status.full;
   assign accept   = req_push && !req_full;

   dtlsrp_front #(
      .OFFSET_BITS(OFFSET_BITS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .item    (req_data),
      .max_len (max_len_ff),
      .push    (front_push),
      .desc    (front_desc)
   );

   dtlsrp_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_desc),
      .pop       (q_pop),
      .head      (q_head),
      .status    (q_status)
   );

   dtlsrp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      front_push |-> !q_status.full)
      else $error("descriptor pushed into a full queue");

   a_type_range: assert property (@(posedge clock) disable iff (reset)
      front_push |-> (front_desc.record_type >= 5'd20) && (front_desc.record_type <= 5'd23))
      else $error("descriptor with a record type outside 20..23");

   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      (csr_write && csr_hit) |=> (max_len_ff == $past(csr_pwdata[15:0])))
      else $error("max_record_length not updated by a write");

   a_pop_refill: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> !rsp_empty)
      else $error("waiting item lost without a pop");
`endif

endmodule
`default_nettype wire
